/* rtl/assert_macros.svh */
// assertion macros used by the splitter rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  `ASSERT_AT(label, clk, rst_n, !(expr), msg)

`endif

/* rtl/ssplit_pkg.sv */
// types, register indexes and byte helpers for the separator splitter
`default_nettype none

package ssplit_pkg;

  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_SEP_BYTES = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEP_LEN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IGN_CASE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP_SEP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT     = 3'd4;

  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
  localparam logic [7:0] ASCII_CASE_OFS = 8'h20;

  // per-cell window control
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

  // one result word
  typedef struct packed {
    logic [7:0] data;
    logic       data_valid;
    logic       piece_end;
    logic       string_done;
    logic       run_last;
  } res_t;

  function automatic logic [7:0] fold_byte(logic [7:0] c, logic ign_case);
    logic [7:0] r;
    r = c;
    if (ign_case && (c inside {[ASCII_UPPER_A:ASCII_UPPER_Z]})) begin
      r = c + ASCII_CASE_OFS;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/ssplit_cell.sv */
// one window cell: holds a byte, shifts toward the head, compares its next byte
`default_nettype none

module ssplit_cell (
  input  var logic                 clk_i,
  input  var logic                 rst_ni,
  input  var ssplit_pkg::cell_ctl_t ctl_i,
  input  var logic [7:0]           nbr_byte_i,
  input  var logic [7:0]           new_byte_i,
  input  var logic [7:0]           sep_byte_i,
  input  var logic                 ign_case_i,
  output logic [7:0]               byte_o,
  output logic                     match_o
);

  logic [7:0] byte_q;
  logic [7:0] byte_d;

  always_comb begin
    byte_d = byte_q;
    if (ctl_i.load) begin
      byte_d = new_byte_i;
    end else if (ctl_i.shift) begin
      byte_d = nbr_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else begin
      byte_q <= byte_d;
    end
  end

  // compare against the byte this cell holds after the current step
  assign match_o = (ssplit_pkg::fold_byte(byte_d, ign_case_i) ==
                    ssplit_pkg::fold_byte(sep_byte_i, ign_case_i));
  assign byte_o  = byte_q;

endmodule

`default_nettype wire

/* rtl/ssplit_obuf.sv */
// two-word result buffer between the window engine and the output channel
`default_nettype none

module ssplit_obuf (
  input  var logic              clk_i,
  input  var logic              rst_ni,
  input  var logic              push_i,
  input  var ssplit_pkg::res_t  res_i,
  output logic                  full_o,
  output logic                  out_valid_o,
  input  var logic              out_ready_i,
  output ssplit_pkg::res_t      res_o
);

  ssplit_pkg::res_t ent_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] cnt_q;
  logic       pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != 2'd0);
  assign full_o      = (cnt_q == 2'd2);
  assign res_o       = ent_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/stream_separator_splitter_unit.sv */
// splits a byte stream into pieces at each occurrence of a separator
// output: result words are registered in the result buffer and offered from it
// throughput: at most one result word per step, so one byte per cycle while each
//   byte pushes one out and the result buffer is not full; a string end flushes
//   the window one byte per step (a match if kept), then pushes the piece end
// reset: window, fill, piece count, result buffer and registers return to defaults
`default_nettype none
`include "assert_macros.svh"

module stream_separator_splitter_unit #(
  parameter int unsigned MAX_SEPARATOR = 8,
  parameter int unsigned COUNT_WIDTH   = 16
) (
  input  var logic                             clk_i,
  input  var logic                             rst_ni,
  input  var logic                             cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  var logic [ssplit_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  var logic [63:0]                      cfg_data_i,
  input  var logic                             in_valid_i,
  output logic                                 in_ready_o,
  input  var logic [7:0]                       data_byte_i,
  input  var logic                             byte_present_i,
  input  var logic                             string_end_i,
  output logic                                 out_valid_o,
  input  var logic                             out_ready_i,
  output logic [7:0]                           out_byte_o,
  output logic                                 out_byte_valid_o,
  output logic                                 piece_end_o,
  output logic                                 string_done_o,
  output logic                                 run_last_o
);

  localparam int unsigned FW    = $clog2(MAX_SEPARATOR + 1);
  localparam int unsigned SEP_W = MAX_SEPARATOR * 8;
  localparam int unsigned CMP_W = 33;

  localparam logic [1:0] PH_INS   = 2'd0;
  localparam logic [1:0] PH_MATCH = 2'd1;
  localparam logic [1:0] PH_END   = 2'd2;

  // configuration
  logic [SEP_W-1:0]       sep_q;
  logic [3:0]             len_q;
  logic                   ign_case_q;
  logic                   keep_q;
  logic [15:0]            lim_q;

  // engine state
  logic [FW-1:0]          fill_q, fill_d;
  logic [COUNT_WIDTH-1:0] pieces_q, pieces_d;
  logic                   busy_q, busy_d;
  logic [1:0]             phase_q, phase_d;
  logic [7:0]             byte_q;
  logic                   end_q;

  logic [FW-1:0]          eff_len;
  logic                   accept;
  logic                   buf_full;
  logic                   op_act;
  logic                   op_nop;
  logic [1:0]             op_phase;
  logic [7:0]             op_byte;
  logic                   op_end;
  logic                   do_shift;
  logic                   do_load;
  logic [FW-1:0]          load_idx;
  logic                   match_en;
  logic                   win_match;
  logic                   push;
  ssplit_pkg::res_t       res;
  ssplit_pkg::res_t       out_res;

  logic [7:0]             cell_byte  [MAX_SEPARATOR];
  logic [MAX_SEPARATOR-1:0] cell_match;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q      <= '0;
      len_q      <= 4'd1;
      ign_case_q <= 1'b0;
      keep_q     <= 1'b0;
      lim_q      <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ssplit_pkg::CFG_SEP_BYTES: sep_q      <= cfg_data_i[SEP_W-1:0];
        ssplit_pkg::CFG_SEP_LEN:   len_q      <= cfg_data_i[3:0];
        ssplit_pkg::CFG_IGN_CASE:  ign_case_q <= cfg_data_i[0];
        ssplit_pkg::CFG_KEEP_SEP:  keep_q     <= cfg_data_i[0];
        ssplit_pkg::CFG_LIMIT:     lim_q      <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // separator length clamped to 1..MAX_SEPARATOR
  always_comb begin
    if (len_q == 4'd0) begin
      eff_len = FW'(1);
    end else if (len_q > 4'(MAX_SEPARATOR)) begin
      eff_len = FW'(MAX_SEPARATOR);
    end else begin
      eff_len = len_q[FW-1:0];
    end
  end

  assign match_en = (lim_q == 16'd0) ||
                    (CMP_W'(pieces_q) < (CMP_W'(lim_q) - CMP_W'(1)));

  // current step comes from the held word or straight from the input
  assign in_ready_o = !busy_q && !buf_full;
  assign accept     = in_valid_i && in_ready_o;
  assign op_act     = busy_q ? !buf_full : accept;
  assign op_nop     = !busy_q && !byte_present_i && !string_end_i;
  assign op_phase   = busy_q ? phase_q : (byte_present_i ? PH_INS : PH_END);
  assign op_byte    = busy_q ? byte_q : data_byte_i;
  assign op_end     = busy_q ? end_q : string_end_i;

  // window control
  always_comb begin
    do_shift = 1'b0;
    do_load  = 1'b0;
    load_idx = fill_q;
    if (op_act && !op_nop) begin
      case (op_phase)
        PH_INS: begin
          do_shift = (fill_q >= eff_len);
          do_load  = (fill_q <= eff_len);
          if (fill_q == eff_len) begin
            load_idx = fill_q - FW'(1);
          end
        end
        PH_MATCH: do_shift = keep_q && (fill_q != '0);
        PH_END:   do_shift = (fill_q != '0);
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < MAX_SEPARATOR; i++) begin : g_cell
    ssplit_pkg::cell_ctl_t ctl;
    logic [7:0]            nbr;

    assign ctl.shift = do_shift;
    assign ctl.load  = do_load && (load_idx == FW'(i));

    if (i == MAX_SEPARATOR - 1) begin : g_tail
      assign nbr = 8'h00;
    end else begin : g_body
      assign nbr = cell_byte[i+1];
    end

    ssplit_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .nbr_byte_i (nbr),
      .new_byte_i (op_byte),
      .sep_byte_i (sep_q[8*i +: 8]),
      .ign_case_i (ign_case_q),
      .byte_o     (cell_byte[i]),
      .match_o    (cell_match[i])
    );
  end

  // cells past the separator length do not take part
  always_comb begin
    win_match = 1'b1;
    for (int i = 0; i < MAX_SEPARATOR; i++) begin
      if ((FW'(i) < eff_len) && !cell_match[i]) begin
        win_match = 1'b0;
      end
    end
  end

  // step sequencer
  always_comb begin
    logic hit;
    hit      = 1'b0;
    push     = 1'b0;
    res      = '0;
    fill_d   = fill_q;
    pieces_d = pieces_q;
    busy_d   = busy_q;
    phase_d  = phase_q;
    if (op_act && !op_nop) begin
      case (op_phase)
        PH_INS: begin
          if (fill_q > eff_len) begin
            // length was lowered: drain oldest bytes first
            push            = 1'b1;
            res.data        = cell_byte[0];
            res.data_valid  = 1'b1;
            fill_d          = fill_q - FW'(1);
            busy_d          = 1'b1;
            phase_d         = PH_INS;
          end else begin
            if (fill_q != eff_len) begin
              fill_d = fill_q + FW'(1);
            end
            hit = (fill_d == eff_len) && match_en && win_match;
            if (fill_q == eff_len) begin
              push           = 1'b1;
              res.data       = cell_byte[0];
              res.data_valid = 1'b1;
              res.run_last   = !hit && !op_end;
            end
            busy_d  = hit || op_end;
            phase_d = hit ? PH_MATCH : PH_END;
          end
        end
        PH_MATCH: begin
          push = 1'b1;
          if (keep_q && (fill_q != '0)) begin
            res.data       = cell_byte[0];
            res.data_valid = 1'b1;
            fill_d         = fill_q - FW'(1);
          end else begin
            res.piece_end = 1'b1;
            res.run_last  = !op_end;
            fill_d        = '0;
            if (pieces_q != {COUNT_WIDTH{1'b1}}) begin
              pieces_d = pieces_q + COUNT_WIDTH'(1);
            end
            busy_d  = op_end;
            phase_d = PH_END;
          end
        end
        PH_END: begin
          push = 1'b1;
          if (fill_q != '0) begin
            res.data       = cell_byte[0];
            res.data_valid = 1'b1;
            fill_d         = fill_q - FW'(1);
            busy_d         = 1'b1;
            phase_d        = PH_END;
          end else begin
            res.piece_end   = 1'b1;
            res.string_done = 1'b1;
            res.run_last    = 1'b1;
            pieces_d        = '0;
            busy_d          = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      pieces_q <= '0;
      busy_q   <= 1'b0;
      phase_q  <= PH_INS;
    end else begin
      fill_q   <= fill_d;
      pieces_q <= pieces_d;
      busy_q   <= busy_d;
      phase_q  <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= data_byte_i;
      end_q  <= string_end_i;
    end
  end

  ssplit_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .res_i       (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (out_res)
  );

  assign out_byte_o       = out_res.data;
  assign out_byte_valid_o = out_res.data_valid;
  assign piece_end_o      = out_res.piece_end;
  assign string_done_o    = out_res.string_done;
  assign run_last_o       = out_res.run_last;

  `ASSERT_NEVER(a_push_into_full, clk_i, rst_ni, push && buf_full,
                "result word pushed into full buffer")
  `ASSERT_NEVER(a_fill_range, clk_i, rst_ni, fill_q > FW'(MAX_SEPARATOR),
                "window fill beyond cell count")
  `ASSERT_AT(a_done_clears, clk_i, rst_ni,
             (push && res.string_done) |=> ((fill_q == '0) && (pieces_q == '0) && !busy_q),
             "string end did not clear window state")
  `ASSERT_NEVER(a_accept_while_busy, clk_i, rst_ni, accept && busy_q,
                "word accepted while previous one still in work")

endmodule

`default_nettype wire

/* test/tb_stream_separator_splitter_unit.sv */
// testbench for the separator splitter: directed and random strings against a predictor
`timescale 1ns / 1ps

module tb_stream_separator_splitter_unit;

  localparam int WIN_DEPTH     = 8;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 1_500_000;
  localparam int MAX_REPORTS   = 10;

  localparam logic [ssplit_pkg::CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd5;
  localparam logic [ssplit_pkg::CFG_IDX_W-1:0] CFG_SPARE_LAST  = 3'd7;

  logic                             clk_i          = 1'b0;
  logic                             rst_ni         = 1'b0;
  logic                             cfg_valid_i    = 1'b0;
  logic                             cfg_ready_o;
  logic [ssplit_pkg::CFG_IDX_W-1:0] cfg_index_i    = '0;
  logic [63:0]                      cfg_data_i     = '0;
  logic                             in_valid_i     = 1'b0;
  logic                             in_ready_o;
  logic [7:0]                       data_byte_i    = '0;
  logic                             byte_present_i = 1'b0;
  logic                             string_end_i   = 1'b0;
  logic                             out_valid_o;
  logic                             out_ready_i    = 1'b0;
  logic [7:0]                       out_byte_o;
  logic                             out_byte_valid_o;
  logic                             piece_end_o;
  logic                             string_done_o;
  logic                             run_last_o;

  // register mirror
  logic [63:0] sep_bytes   = '0;
  logic [3:0]  sep_len_reg = 4'd1;
  logic        fold_case   = 1'b0;
  logic        keep_sep    = 1'b0;
  logic [15:0] max_pieces  = '0;

  // splitter state mirror
  logic [7:0]  win_bytes [WIN_DEPTH];
  int          win_fill    = 0;
  logic [15:0] piece_count = '0;

  ssplit_pkg::res_t step_words [12];
  int               step_n;
  ssplit_pkg::res_t piece_words_due [$];

  bit idling_on   = 1'b1;
  int stall_left  = 0;
  int cycle_count = 0;
  int mismatches  = 0;
  int items_sent  = 0;
  int words_seen  = 0;
  int reg_writes  = 0;

  stream_separator_splitter_unit DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .data_byte_i      (data_byte_i),
    .byte_present_i   (byte_present_i),
    .string_end_i     (string_end_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_byte_o       (out_byte_o),
    .out_byte_valid_o (out_byte_valid_o),
    .piece_end_o      (piece_end_o),
    .string_done_o    (string_done_o),
    .run_last_o       (run_last_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still due", cycle_count,
               piece_words_due.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_len(input int pct);
    if (!idling_on || $urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
    return $urandom_range(1, 3);
  endfunction

  always @(posedge clk_i) begin
    if (!idling_on) begin
      stall_left = 0;
      out_ready_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      stall_left = idle_len(30);
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic bit is_upper(input logic [7:0] c);
    return c inside {[ssplit_pkg::ASCII_UPPER_A:ssplit_pkg::ASCII_UPPER_Z]};
  endfunction

  function automatic logic [7:0] folded(input logic [7:0] c);
    return (fold_case && is_upper(c)) ? c + ssplit_pkg::ASCII_CASE_OFS : c;
  endfunction

  function automatic int eff_len();
    if (sep_len_reg == 4'd0) return 1;
    if (sep_len_reg > WIN_DEPTH) return WIN_DEPTH;
    return sep_len_reg;
  endfunction

  function automatic bit window_hits(input int len);
    int i;
    for (i = 0; i < len; i++) begin
      if (folded(win_bytes[i]) != folded(sep_bytes[8*i +: 8])) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic add_word(input logic [7:0] b, input logic v, input logic pe, input logic done);
    step_words[step_n] = {b, v, pe, done, 1'b0};
    step_n++;
  endtask

  task automatic shift_out();
    int i;
    add_word(win_bytes[0], 1'b1, 1'b0, 1'b0);
    for (i = 1; i < WIN_DEPTH; i++) win_bytes[i-1] = win_bytes[i];
    win_bytes[WIN_DEPTH-1] = 8'h00;
    win_fill--;
  endtask

  task automatic clear_window();
    int i;
    for (i = 0; i < WIN_DEPTH; i++) win_bytes[i] = 8'h00;
    win_fill = 0;
  endtask

  // words one input word produces, appended in order to piece_words_due
  task automatic cut_pieces(input logic [7:0] b, input logic present, input logic fin);
    int               len;
    int               i;
    ssplit_pkg::res_t w;
    step_n = 0;
    len = eff_len();
    if (present) begin
      // a shorter separator than the window holds pushes out the surplus first
      while (win_fill >= len) shift_out();
      win_bytes[win_fill] = b;
      win_fill++;
      if (win_fill == len && (max_pieces == 16'd0 || piece_count < max_pieces - 16'd1) &&
          window_hits(len)) begin
        if (keep_sep) begin
          for (i = 0; i < len; i++) add_word(win_bytes[i], 1'b1, 1'b0, 1'b0);
        end
        add_word(8'h00, 1'b0, 1'b1, 1'b0);
        clear_window();
        if (piece_count != 16'hFFFF) piece_count++;
      end
    end
    if (fin) begin
      while (win_fill > 0) shift_out();
      add_word(8'h00, 1'b0, 1'b1, 1'b1);
      clear_window();
      piece_count = '0;
    end
    for (i = 0; i < step_n; i++) begin
      w = step_words[i];
      w.run_last = (i == step_n - 1);
      piece_words_due = {piece_words_due, w};
    end
  endtask

  // ---------------------------------------------------------------- checker

  always @(posedge clk_i) begin : result_check
    ssplit_pkg::res_t want;
    ssplit_pkg::res_t got;
    bit               bad;
    if (rst_ni && out_valid_o && out_ready_i) begin
      words_seen++;
      got = {out_byte_o, out_byte_valid_o, piece_end_o, string_done_o, run_last_o};
      bad = 1'b0;
      if (piece_words_due.size() == 0) begin
        want = '0;
        bad = 1'b1;
      end else begin
        want = piece_words_due.pop_front();
        bad = (got.data !== want.data) || (got.data_valid !== want.data_valid) ||
              (got.piece_end !== want.piece_end) || (got.string_done !== want.string_done) ||
              (got.run_last !== want.run_last);
      end
      if (bad) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("mismatch at cycle %0d%s: expected byte %h valid %b end %b done %b last %b",
                   cycle_count, (piece_words_due.size() == 0 && want == '0) ? " (none due)" : "",
                   want.data, want.data_valid, want.piece_end, want.string_done, want.run_last);
          $display("  got byte %h valid %b end %b done %b last %b",
                   got.data, got.data_valid, got.piece_end, got.string_done, got.run_last);
        end
      end
    end
  end

  // ---------------------------------------------------------------- drivers

  task automatic send_item(input logic [7:0] b, input logic present, input logic fin);
    int gap;
    gap = idle_len(35);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    data_byte_i    <= b;
    byte_present_i <= present;
    string_end_i   <= fin;
    cut_pieces(b, present, fin);
    if (present || fin) items_sent++;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // drains all due words, then lets a bare or trailing word settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (piece_words_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [ssplit_pkg::CFG_IDX_W-1:0] idx, input logic [63:0] val,
                           input bit is_last);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      ssplit_pkg::CFG_SEP_BYTES: sep_bytes   = val;
      ssplit_pkg::CFG_SEP_LEN:   sep_len_reg = val[3:0];
      ssplit_pkg::CFG_IGN_CASE:  fold_case   = val[0];
      ssplit_pkg::CFG_KEEP_SEP:  keep_sep    = val[0];
      ssplit_pkg::CFG_LIMIT:     max_pieces  = val[15:0];
      default: ;
    endcase
    reg_writes++;
    if (is_last) cfg_valid_i <= 1'b0;
  endtask

  // upper data bits carry noise, the register keeps only its own width
  task automatic configure(input logic [63:0] sep, input logic [3:0] len, input logic ign,
                           input logic keep, input logic [15:0] lim, input bit with_spare);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    write_reg(ssplit_pkg::CFG_SEP_BYTES, sep, 1'b0);
    write_reg(ssplit_pkg::CFG_SEP_LEN, {junk[63:4], len}, 1'b0);
    write_reg(ssplit_pkg::CFG_IGN_CASE, {junk[62:0], ign}, 1'b0);
    write_reg(ssplit_pkg::CFG_KEEP_SEP, {junk[63:1], keep}, 1'b0);
    if (with_spare) begin
      write_reg(ssplit_pkg::CFG_IDX_W'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)),
                junk, 1'b0);
    end
    write_reg(ssplit_pkg::CFG_LIMIT, {junk[47:0], lim}, 1'b1);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_reset_defaults();
    // separator is a single zero byte out of reset
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'hA5, 1'b0, 1'b0);
    send_item(8'h5A, 1'b0, 1'b1);
  endtask

  task automatic test_case_folding();
    wait_idle();
    configure(64'h6241, 4'd2, 1'b1, 1'b1, 16'd0, 1'b0);
    send_item("a", 1'b1, 1'b0);
    send_item("B", 1'b1, 1'b0);
    send_item("Z", 1'b1, 1'b1);
    wait_idle();
    configure(64'h6241, 4'd2, 1'b0, 1'b0, 16'd0, 1'b0);
    send_item("a", 1'b1, 1'b0);
    send_item("B", 1'b1, 1'b0);
    send_item("A", 1'b1, 1'b0);
    send_item("b", 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    // neighbors of the letter ranges must not fold
    wait_idle();
    configure(64'h5B40, 4'd2, 1'b1, 1'b0, 16'd0, 1'b0);
    send_item(8'h60, 1'b1, 1'b0);
    send_item(8'h7B, 1'b1, 1'b0);
    send_item(8'h40, 1'b1, 1'b0);
    send_item(8'h5B, 1'b1, 1'b1);
  endtask

  task automatic test_piece_limit();
    wait_idle();
    configure(64'h2C, 4'd1, 1'b0, 1'b0, 16'd2, 1'b0);
    send_item(",", 1'b1, 1'b0);
    send_item(",", 1'b1, 1'b0);
    send_item(",", 1'b1, 1'b1);
    wait_idle();
    configure(64'h2C, 4'd1, 1'b0, 1'b0, 16'd1, 1'b0);
    send_item(",", 1'b1, 1'b1);
  endtask

  task automatic test_long_separator();
    logic [63:0] pattern;
    int          i;
    // length 15 counts as the full window, two letters arrive in the other case
    pattern = 64'hFF00_7A61_807F_01FE;
    wait_idle();
    configure(64'hFF00_5A41_807F_01FE, 4'd15, 1'b1, 1'b1, 16'd0, 1'b1);
    for (i = 0; i < WIN_DEPTH; i++) send_item(pattern[8*i +: 8], 1'b1, 1'b0);
    send_item(8'h11, 1'b1, 1'b0);
    send_item(8'h22, 1'b1, 1'b0);
    send_item(8'h33, 1'b1, 1'b0);
    // shrink the separator while three bytes sit in the window
    wait_idle();
    write_reg(ssplit_pkg::CFG_SEP_LEN, 64'd0, 1'b1);
    send_item(8'h44, 1'b1, 1'b1);
  endtask

  task automatic random_config(input bit with_spare);
    logic [63:0] sep;
    logic [3:0]  len;
    logic [15:0] lim;
    int          i;
    int          r;
    sep = {$urandom, $urandom};
    for (i = 0; i < WIN_DEPTH; i++) begin
      if ($urandom_range(0, 1)) begin
        sep[8*i +: 8] = 8'(ssplit_pkg::ASCII_UPPER_A + $urandom_range(0, 25) +
                           ($urandom_range(0, 1) ? ssplit_pkg::ASCII_CASE_OFS : 8'h00));
      end
    end
    r = $urandom_range(0, 99);
    if (r < 70) len = 4'($urandom_range(1, 3));
    else if (r < 85) len = 4'($urandom_range(4, 8));
    else len = 4'($urandom_range(8, 15) + 1);  // 16 wraps to zero
    r = $urandom_range(0, 99);
    if (r < 40) lim = 16'd0;
    else if (r < 70) lim = 16'($urandom_range(1, 4));
    else if (r < 80) lim = 16'hFFFF;
    else lim = 16'($urandom_range(0, 65535));
    configure(sep, len, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), lim, with_spare);
  endtask

  // mostly separator-laden text, some partial separators, noise and bare words
  task automatic send_string(input bit bare_end, input bit may_retune);
    logic [7:0]  text [$];
    logic [7:0]  c;
    logic [63:0] junk;
    int          parts;
    int          filler;
    int          len;
    int          cut;
    int          k;
    int          i;
    int          j;
    len = eff_len();
    parts = $urandom_range(0, 4);
    for (i = 0; i < parts; i++) begin
      filler = $urandom_range(0, 4);
      for (j = 0; j < filler; j++) begin
        k = $urandom_range(0, len - 1);
        c = 8'($urandom);
        if ($urandom_range(0, 1)) c = sep_bytes[8*k +: 8];
        text = {text, c};
      end
      cut = ($urandom_range(0, 99) < 80) ? len : $urandom_range(0, len - 1);
      for (j = 0; j < cut; j++) begin
        c = sep_bytes[8*j +: 8];
        if ((is_upper(c) || is_upper(c ^ ssplit_pkg::ASCII_CASE_OFS)) &&
            $urandom_range(0, 3) == 0) begin
          c = c ^ ssplit_pkg::ASCII_CASE_OFS;
        end
        text = {text, c};
      end
    end
    for (i = 0; i < text.size(); i++) begin
      if ($urandom_range(0, 99) < 6) begin
        c = 8'($urandom);
        send_item(c, 1'b0, 1'b0);
      end
      if (may_retune && i == text.size() / 2 && $urandom_range(0, 9) == 0) begin
        wait_idle();
        junk = {$urandom, $urandom};
        write_reg(ssplit_pkg::CFG_SEP_LEN,
                  {junk[63:4], 4'($urandom_range(0, sep_len_reg))}, 1'b1);
      end
      send_item(text[i], 1'b1, !bare_end && i == text.size() - 1);
    end
    if (bare_end || text.size() == 0) begin
      c = 8'($urandom);
      send_item(c, 1'b0, 1'b1);
    end
  endtask

  task automatic test_random_strings();
    int phase;
    int target;
    for (phase = 0; phase < 8; phase++) begin
      wait_idle();
      random_config(phase == 3);
      idling_on = (phase != 5);
      target = items_sent + 40;
      while (items_sent < target) send_string($urandom_range(0, 99) < 35, phase >= 2);
    end
    idling_on = 1'b1;
  endtask

  initial begin
    int i;
    for (i = 0; i < WIN_DEPTH; i++) win_bytes[i] = 8'h00;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_case_folding();
    test_piece_limit();
    test_long_separator();
    test_random_strings();
    wait_idle();
    $display("covered %0d input words and %0d register writes: defaults, case folding,",
             items_sent, reg_writes);
    $display("piece limits, long and shrinking separators and random strings; %0d words checked",
             words_seen);
    if (mismatches == 0 && piece_words_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d words never arrived", mismatches, piece_words_due.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/ssplit_pkg.sv
rtl/ssplit_cell.sv
rtl/ssplit_obuf.sv
rtl/stream_separator_splitter_unit.sv
test/tb_stream_separator_splitter_unit.sv
